@@ sv/rxls_pkg.sv @@
// rxls_pkg: shared types and constants of the receive link statistics block.
// No dependencies; compiled first.
package rxls_pkg;

    localparam int unsigned CNT_W     = 32;
    localparam int unsigned SUM_W     = 48;
    localparam int unsigned AVG_W     = 16;
    localparam int unsigned DIV_STEPS = SUM_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    // Opcodes of the input channel
    localparam logic [2:0] OP_GOOD_FRAME = 3'd0;
    localparam logic [2:0] OP_RX_ERROR   = 3'd1;
    localparam logic [2:0] OP_START      = 3'd2;
    localparam logic [2:0] OP_STOP       = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    typedef enum logic [2:0] {
        CMD_FRAME,
        CMD_ERROR,
        CMD_START,
        CMD_STOP,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    // One queued command; power estimate is already shifted down
    typedef struct packed {
        cmd_kind_t          kind;
        logic [CNT_W-1:0]   seq;
        logic [AVG_W-1:0]   power_est;
        logic [AVG_W-1:0]   acc;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } bk_state_t;

    // One restoring division step
    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [SUM_W-1:0] dvd;
    } div_t;

endpackage

@@ sv/rxls_if.sv @@
// rxls_if: channel interfaces of the receive link statistics block.
// No dependencies.
interface rxls_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] sequence_number;
    logic [9:0]  frame_length;
    logic [31:0] channel_power;
    logic [15:0] accumulator_count;

    modport source (output valid, opcode, sequence_number, frame_length,
                    channel_power, accumulator_count, input ready);
    modport sink   (input valid, opcode, sequence_number, frame_length,
                    channel_power, accumulator_count, output ready);
endinterface

interface rxls_cfg_if;
    logic valid;
    logic ready;
    logic radio_configured;

    modport source (output valid, radio_configured, input ready);
    modport sink   (input valid, radio_configured, output ready);
endinterface

interface rxls_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [31:0] total_received;
    logic [31:0] lost_packets;
    logic [31:0] crc_errors;
    logic [15:0] power_average;
    logic [15:0] snr_average;
    logic [15:0] quality_average;

    modport source (output valid, status, total_received, lost_packets, crc_errors,
                    power_average, snr_average, quality_average, input ready);
    modport sink   (input valid, status, total_received, lost_packets, crc_errors,
                    power_average, snr_average, quality_average, output ready);
endinterface

@@ sv/rx_link_statistics_top.sv @@
// rx_link_statistics_top: top level of the receive link statistics block.
// Depends on rxls_pkg, rxls_if, rxls_front, rxls_queue, rxls_back.
//
// Receiver events and test commands arrive as transactions on rx_in. The front
// end decodes each one in the cycle it is accepted, drops unused opcodes and
// oversized frames, and pushes the rest into a QUEUE_DEPTH-entry command queue;
// rx_in.ready is low only while that queue is full. The back end pops one
// command per cycle while idle (start, stop and reset also need a free result
// slot); frames, errors, start, stop and reset complete at the pop. A read
// statistics command runs a bit-serial restoring divider (power and quality
// sums in parallel, one quotient bit per cycle) and takes no new command until
// its result is registered; this loop sets the worst-case rate. Start, stop, read
// and reset each produce one transaction on stats_out through an output register,
// so the back end keeps working frames while a result waits to be taken. The cfg
// channel is always ready and should be written only while the block is idle.
module rx_link_statistics_top #(
    parameter int unsigned MAX_FRAME_LEN = 127,
    parameter int unsigned QUEUE_DEPTH   = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    rxls_in_if.sink      rx_in,
    rxls_cfg_if.sink     cfg,
    rxls_out_if.source   stats_out
);
    import rxls_pkg::*;

    // front to queue
    logic q_push;
    cmd_t q_push_cmd;
    logic q_full;

    // queue to back
    logic q_pop;
    cmd_t q_head;
    logic q_empty;

    rxls_front #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_front (
        .rx_in    (rx_in),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    rxls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    rxls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .stats_out (stats_out)
    );

endmodule

@@ sv/rxls_front.sv @@
// rxls_front: accepts input transactions, decodes and filters them into commands.
// Depends on rxls_pkg and rxls_if.
module rxls_front #(
    parameter int unsigned MAX_FRAME_LEN = 127
) (
    rxls_in_if.sink         rx_in,
    input  logic            q_full,
    output logic            push,
    output rxls_pkg::cmd_t  push_cmd
);
    import rxls_pkg::*;

    logic keep;

    assign rx_in.ready = !q_full;

    always_comb
    begin
        keep          = 1'b1;
        push_cmd.kind = CMD_FRAME;
        case (rx_in.opcode)
            OP_GOOD_FRAME:
            begin
                // oversized frames never touch the statistics
                keep = (rx_in.frame_length <= 10'(MAX_FRAME_LEN));
            end
            OP_RX_ERROR: push_cmd.kind = CMD_ERROR;
            OP_START:    push_cmd.kind = CMD_START;
            OP_STOP:     push_cmd.kind = CMD_STOP;
            OP_READ:     push_cmd.kind = CMD_READ;
            OP_CLEAR:    push_cmd.kind = CMD_CLEAR;
            default:     keep = 1'b0;
        endcase
        push_cmd.seq       = rx_in.sequence_number;
        push_cmd.power_est = rx_in.channel_power[31:16];
        push_cmd.acc       = rx_in.accumulator_count;
    end

    assign push = rx_in.valid && rx_in.ready && keep;

endmodule

@@ sv/rxls_queue.sv @@
// rxls_queue: small command FIFO between front and back.
// Depends on rxls_pkg.
module rxls_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rxls_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output rxls_pkg::cmd_t  head,
    output logic            empty
);
    import rxls_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);

    cmd_t              mem_reg [DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign full  = (fill_reg == FILL_W'(DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ sv/rxls_back.sv @@
// rxls_back: executes queued commands, holds statistics, serial divider, result register.
// Depends on rxls_pkg and rxls_if.
module rxls_back (
    input  logic            clk,
    input  logic            rst_n,
    rxls_cfg_if.sink        cfg,
    input  rxls_pkg::cmd_t  head,
    input  logic            empty,
    output logic            pop,
    rxls_out_if.source      stats_out
);
    import rxls_pkg::*;

    function automatic div_t div_step(div_t d, logic [CNT_W-1:0] divisor);
        logic [CNT_W:0] t;
        logic           ge;
        div_t           r;
        t     = {d.rem, d.dvd[SUM_W-1]};
        ge    = (t >= {1'b0, divisor});
        r.rem = ge ? CNT_W'(t - {1'b0, divisor}) : t[CNT_W-1:0];
        r.dvd = {d.dvd[SUM_W-2:0], ge};
        return r;
    endfunction

    bk_state_t         state_reg, state_next;
    logic              cfg_reg, cfg_next;
    logic              running_reg, running_next;
    logic              seq_valid_reg, seq_valid_next;
    logic [CNT_W-1:0]  prev_seq_reg, prev_seq_next;
    logic [CNT_W-1:0]  rx_cnt_reg, rx_cnt_next;
    logic [CNT_W-1:0]  lost_reg, lost_next;
    logic [CNT_W-1:0]  err_reg, err_next;
    logic [SUM_W-1:0]  pwr_sum_reg, pwr_sum_next;
    logic [SUM_W-1:0]  qual_sum_reg, qual_sum_next;
    logic [CNT_W-1:0]  metric_reg, metric_next;
    div_t              div_p_reg, div_p_next;
    div_t              div_q_reg, div_q_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic              out_valid_reg, out_valid_next;
    logic              res_status_reg, res_status_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  lost_out_reg, lost_out_next;
    logic [CNT_W-1:0]  crc_out_reg, crc_out_next;
    logic [AVG_W-1:0]  pavg_reg, pavg_next;
    logic [AVG_W-1:0]  qavg_reg, qavg_next;

    logic              slot_free;
    logic              pop_ok;
    logic [CNT_W-1:0]  expected;

    assign cfg.ready = 1'b1;
    assign slot_free = !out_valid_reg || stats_out.ready;
    // frames, errors and reads may leave without a free result slot
    assign pop_ok    = !empty && ((head.kind == CMD_FRAME) || (head.kind == CMD_ERROR)
                                  || (head.kind == CMD_READ) || slot_free);
    assign expected  = prev_seq_reg + 1'b1;

    assign stats_out.valid           = out_valid_reg;
    assign stats_out.status          = res_status_reg;
    assign stats_out.total_received  = total_reg;
    assign stats_out.lost_packets    = lost_out_reg;
    assign stats_out.crc_errors      = crc_out_reg;
    assign stats_out.power_average   = pavg_reg;
    assign stats_out.snr_average     = qavg_reg;
    assign stats_out.quality_average = qavg_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop_ok && (head.kind == CMD_READ))
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop             = 1'b0;
        cfg_next        = cfg_reg;
        running_next    = running_reg;
        seq_valid_next  = seq_valid_reg;
        prev_seq_next   = prev_seq_reg;
        rx_cnt_next     = rx_cnt_reg;
        lost_next       = lost_reg;
        err_next        = err_reg;
        pwr_sum_next    = pwr_sum_reg;
        qual_sum_next   = qual_sum_reg;
        metric_next     = metric_reg;
        div_p_next      = div_p_reg;
        div_q_next      = div_q_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !stats_out.ready;
        res_status_next = res_status_reg;
        total_next      = total_reg;
        lost_out_next   = lost_out_reg;
        crc_out_next    = crc_out_reg;
        pavg_next       = pavg_reg;
        qavg_next       = qavg_reg;

        if (cfg.valid)
        begin
            cfg_next = cfg.radio_configured;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (pop_ok)
                begin
                    pop = 1'b1;
                    case (head.kind)
                        CMD_FRAME:
                        begin
                            if (running_reg)
                            begin
                                rx_cnt_next = rx_cnt_reg + 1'b1;
                                seq_valid_next = 1'b1;
                                if (seq_valid_reg && (head.seq > expected))
                                begin
                                    lost_next = lost_reg + (head.seq - expected);
                                end
                                prev_seq_next = head.seq;
                                pwr_sum_next  = pwr_sum_reg + SUM_W'(head.power_est);
                                qual_sum_next = qual_sum_reg + SUM_W'(head.acc);
                                metric_next   = metric_reg + 1'b1;
                            end
                        end
                        CMD_ERROR:
                        begin
                            if (running_reg)
                            begin
                                err_next = err_reg + 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            div_p_next.rem = '0;
                            div_p_next.dvd = pwr_sum_reg;
                            div_q_next.rem = '0;
                            div_q_next.dvd = qual_sum_reg;
                            step_next      = '0;
                        end
                        default:
                        begin
                            // start/stop/clear give zeros; status 1 on unconfigured start
                            out_valid_next  = 1'b1;
                            res_status_next = 1'b0;
                            total_next      = '0;
                            lost_out_next   = '0;
                            crc_out_next    = '0;
                            pavg_next       = '0;
                            qavg_next       = '0;
                            if ((head.kind == CMD_START) && !cfg_reg)
                            begin
                                res_status_next = 1'b1;
                            end
                            if (head.kind == CMD_STOP)
                            begin
                                running_next = 1'b0;
                            end
                            if (((head.kind == CMD_START) && cfg_reg)
                                || (head.kind == CMD_CLEAR))
                            begin
                                if (head.kind == CMD_START)
                                begin
                                    running_next = 1'b1;
                                end
                                seq_valid_next = 1'b0;
                                prev_seq_next  = '0;
                                rx_cnt_next    = '0;
                                lost_next      = '0;
                                err_next       = '0;
                                pwr_sum_next   = '0;
                                qual_sum_next  = '0;
                                metric_next    = '0;
                            end
                        end
                    endcase
                end
            end
            BK_DIV:
            begin
                div_p_next = div_step(div_p_reg, metric_reg);
                div_q_next = div_step(div_q_reg, metric_reg);
                step_next  = step_reg + 1'b1;
            end
            BK_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    res_status_next = 1'b0;
                    total_next      = rx_cnt_reg;
                    lost_out_next   = lost_reg;
                    crc_out_next    = err_reg;
                    pavg_next       = (metric_reg != '0) ? div_p_reg.dvd[AVG_W-1:0] : '0;
                    qavg_next       = (metric_reg != '0) ? div_q_reg.dvd[AVG_W-1:0] : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cfg_reg       <= 1'b0;
            running_reg   <= 1'b0;
            seq_valid_reg <= 1'b0;
            prev_seq_reg  <= '0;
            rx_cnt_reg    <= '0;
            lost_reg      <= '0;
            err_reg       <= '0;
            pwr_sum_reg   <= '0;
            qual_sum_reg  <= '0;
            metric_reg    <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            running_reg   <= running_next;
            seq_valid_reg <= seq_valid_next;
            prev_seq_reg  <= prev_seq_next;
            rx_cnt_reg    <= rx_cnt_next;
            lost_reg      <= lost_next;
            err_reg       <= err_next;
            pwr_sum_reg   <= pwr_sum_next;
            qual_sum_reg  <= qual_sum_next;
            metric_reg    <= metric_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_p_reg      <= div_p_next;
        div_q_reg      <= div_q_next;
        res_status_reg <= res_status_next;
        total_reg      <= total_next;
        lost_out_reg   <= lost_out_next;
        crc_out_reg    <= crc_out_next;
        pavg_reg       <= pavg_next;
        qavg_reg       <= qavg_next;
    end

    // divisor and statistics hold still while a division runs
    a_div_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |=> $stable(metric_reg) && $stable(rx_cnt_reg))
        else $error("statistics changed during division");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == BK_DIV) && (step_reg != STEP_W'(DIV_STEPS - 1)))
        |=> (state_reg == BK_DIV) && (step_reg == $past(step_reg) + 1'b1))
        else $error("divider step sequence broken");

    a_idle_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (head.kind == CMD_FRAME) && !running_reg) |=> $stable(rx_cnt_reg))
        else $error("frame counted while stopped");

    a_counts_agree: assert property (@(posedge clk) disable iff (!rst_n)
        rx_cnt_reg == metric_reg)
        else $error("received count and metric count differ");

endmodule
